@@ hw/rtl/flt_pkg.sv @@
package flt_pkg;

	localparam int KEY_W = 48;
	localparam int TABLE_DEPTH_DEF = 16;

	typedef logic [KEY_W-1:0] key_t;

	localparam logic [1:0] CMD_CLASSIFY = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic which_table;
		logic [31:0] source_ip;
		logic [15:0] source_port;
		logic is_syn;
	} req_t;

	typedef struct packed {
		logic hit;
		logic from_second;
		logic unknown_flow;
	} rsp_t;

	// Control from the sequencer to one table
	typedef struct packed {
		logic start;
		logic apply;
		logic ins;
	} chain_ctl_t;

	// Search status of one table
	typedef struct packed {
		logic done;
		logic hit;
	} chain_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

endpackage

@@ hw/rtl/flt_cell.sv @@
module flt_cell (
	input logic clk,
	input logic arst_n,
	input flt_pkg::key_t key,
	input flt_pkg::key_t prev_key,
	input logic tok_in,
	input logic start,
	input logic promote,
	input logic fill,
	output flt_pkg::key_t entry,
	output logic pass_out,
	output logic hit_stop,
	output logic empty_stop
);
	import flt_pkg::*;

	key_t entry_q;
	logic tok_q;
	logic vis_q;
	logic eq;
	logic emp;

	assign eq = (entry_q == key);
	assign emp = (entry_q == '0);
	assign hit_stop = tok_q & eq;
	assign empty_stop = tok_q & emp & ~eq;
	assign pass_out = tok_q & ~eq & ~emp;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			tok_q <= 1'b0;
			vis_q <= 1'b0;
		end else begin
			if (start) begin
				tok_q <= tok_in;
				vis_q <= tok_in;
			end else begin
				// hold the token where the search stopped
				tok_q <= tok_in | hit_stop | empty_stop;
				vis_q <= vis_q | tok_in;
			end
			if (promote && vis_q) begin
				entry_q <= prev_key;
			end else if (fill && empty_stop) begin
				entry_q <= key;
			end
		end
	end

endmodule

@@ hw/rtl/flt_chain.sv @@
module flt_chain #(
	parameter int TABLE_DEPTH = flt_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input flt_pkg::key_t key,
	input flt_pkg::chain_ctl_t ctl,
	output flt_pkg::chain_sts_t sts
);
	import flt_pkg::*;

	key_t ent [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] pass;
	logic [TABLE_DEPTH-1:0] hs;
	logic [TABLE_DEPTH-1:0] es;
	logic [TABLE_DEPTH-1:0] tin;
	logic off_q;
	logic found;
	logic emp_found;
	logic promote;
	logic fill;

	assign found = |hs;
	assign emp_found = |es;
	// an inserting miss on a full table drops the last entry and puts the key up front
	assign promote = ctl.apply & (found | (ctl.ins & off_q));
	assign fill = ctl.apply & ctl.ins & emp_found;

	assign sts.done = found | emp_found | off_q;
	assign sts.hit = found;

	genvar i;
	generate
		for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			key_t prev;
			if (i == 0) begin : g_head
				assign tin[i] = ctl.start;
				assign prev = key;
			end else begin : g_body
				assign tin[i] = pass[i-1] & ~ctl.start;
				assign prev = ent[i-1];
			end
			flt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.key(key),
				.prev_key(prev),
				.tok_in(tin[i]),
				.start(ctl.start),
				.promote(promote),
				.fill(fill),
				.entry(ent[i]),
				.pass_out(pass[i]),
				.hit_stop(hs[i]),
				.empty_stop(es[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 1'b0;
		end else if (ctl.start) begin
			off_q <= 1'b0;
		end else if (pass[TABLE_DEPTH-1]) begin
			off_q <= 1'b1;
		end
	end

endmodule

@@ hw/rtl/two_table_lru_flow_tracker_unit.sv @@
// Two-table LRU flow tracker.
// Request channel (req, req_valid, req_stall) carries one command beat: classify,
// insert into a table, or lookup-and-promote in a table. Response channel
// (rsp, rsp_valid, rsp_stall) returns exactly one beat per request, in order.
// Each table is a row of cells, entry 0 most recent. A search token enters cell 0
// and moves one cell per cycle until it meets the key or the first empty entry,
// or falls off the end; the update (promote, fill in place, or replace the last
// entry) then happens in all cells at once, each shifted cell taking its neighbor's entry.
// An all-zero key or an unused command loads the response register directly on
// accept; a search beat loads it once the token stops at the match or the first
// empty entry, or falls off the end of a full table that misses.
// A non-SYN classify searches both tables side by side and waits for the slower one.
// One request is searched at a time: no new beat is taken until the running
// search has finished, and the token ripple through the cells sets how long it runs.
// A finished response waits in the response register while rsp_stall is high.
// A search beat is still taken then and runs; its result holds in the sequencer
// until that register frees, and req_stall stays high meanwhile. An all-zero key
// or unused command waits on the request side until the register frees.
// Reset clears both tables to empty and drops any pending beat.
module two_table_lru_flow_tracker_unit #(
	parameter int TABLE_DEPTH = flt_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input flt_pkg::req_t req,
	input logic req_valid,
	output logic req_stall,
	output flt_pkg::rsp_t rsp,
	output logic rsp_valid,
	input logic rsp_stall
);
	import flt_pkg::*;

	state_t state_q;
	state_t state_d;
	key_t key_q;
	logic both_q;
	logic ins_q;
	logic tgt_q;
	rsp_t rsp_q;
	rsp_t rsp_d;
	logic rsp_valid_q;
	logic rsp_load;

	chain_ctl_t ctl_a;
	chain_ctl_t ctl_b;
	chain_sts_t sts_a;
	chain_sts_t sts_b;

	logic accept;
	logic out_free;
	key_t req_key;
	logic key_zero;
	logic is_cls;
	logic is_ins;
	logic is_lkp;
	logic searches;
	logic d_both;
	logic d_ins;
	logic d_tgt;
	logic ready_go;

	assign out_free = ~rsp_valid_q | ~rsp_stall;
	// a search beat may start while the response register still waits
	assign req_stall = (state_q != ST_IDLE) | (~out_free & ~searches);
	assign accept = req_valid & ~req_stall;

	// decode the incoming beat
	assign req_key = {req.source_ip, req.source_port};
	assign key_zero = (req_key == '0);
	assign is_cls = (req.cmd == CMD_CLASSIFY);
	assign is_ins = (req.cmd == CMD_INSERT);
	assign is_lkp = (req.cmd == CMD_LOOKUP);
	assign searches = (is_cls | is_ins | is_lkp) & ~key_zero;
	assign d_both = is_cls & ~req.is_syn;
	assign d_ins = (is_cls & req.is_syn) | is_ins;
	assign d_tgt = is_cls ? 1'b0 : req.which_table;

	assign ready_go = both_q ? (sts_a.done & sts_b.done) : (tgt_q ? sts_b.done : sts_a.done);

	flt_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_first (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_q),
		.ctl(ctl_a),
		.sts(sts_a)
	);

	flt_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_second (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_q),
		.ctl(ctl_b),
		.sts(sts_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the command; the key register feeds both rows
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req_key;
			both_q <= d_both;
			ins_q <= d_ins;
			tgt_q <= d_tgt;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl_a = '0;
		ctl_b = '0;
		rsp_load = 1'b0;
		rsp_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (searches) begin
						// launch a token into each table that this command reads
						ctl_a.start = d_both | ~d_tgt;
						ctl_b.start = d_both | d_tgt;
						state_d = ST_SEARCH;
					end else begin
						// zero key or unused command: answer at once, tables untouched
						rsp_load = 1'b1;
						rsp_d.unknown_flow = is_cls & ~req.is_syn;
					end
				end
			end
			ST_SEARCH: begin
				if (ready_go && out_free) begin
					rsp_load = 1'b1;
					state_d = ST_IDLE;
					if (both_q) begin
						if (sts_a.hit) begin
							ctl_a.apply = 1'b1;
							rsp_d.hit = 1'b1;
						end else if (sts_b.hit) begin
							ctl_b.apply = 1'b1;
							rsp_d.hit = 1'b1;
							rsp_d.from_second = 1'b1;
						end else begin
							// unknown flow: insert into the first table
							ctl_a.apply = 1'b1;
							ctl_a.ins = 1'b1;
							rsp_d.unknown_flow = 1'b1;
						end
					end else if (tgt_q) begin
						ctl_b.apply = 1'b1;
						ctl_b.ins = ins_q;
						rsp_d.hit = sts_b.hit;
					end else begin
						ctl_a.apply = 1'b1;
						ctl_a.ins = ins_q;
						rsp_d.hit = sts_a.hit;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_a.apply && ctl_b.apply))
		else $error("both tables updated in one cycle");

	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_a.start || ctl_b.start) |-> accept)
		else $error("search launched without an accepted beat");

	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.unknown_flow && rsp_q.hit)
		&& !(rsp_q.from_second && !rsp_q.hit))
		else $error("inconsistent response flags");

	a_search_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && searches) |=> (state_q == ST_SEARCH))
		else $error("search did not begin after accept");

endmodule
